FILE: hdl/static_linked_list_engine_assert.svh
// Assertion macros for the static linked list engine.
// Expects a clock named aclk and an active-low synchronous reset named aresetn in scope.
`ifndef STATIC_LINKED_LIST_ENGINE_ASSERT_SVH
`define STATIC_LINKED_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked on every edge outside reset.
`define SLLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Condition on one edge implies a condition on the next edge.
`define SLLE_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`else

`define SLLE_ASSERT(lbl, prop, msg)
`define SLLE_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

FILE: hdl/slle_pkg.sv
// Shared types and constants for the static linked list engine.
// No dependencies.
package slle_pkg;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_TRAVERSE = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD_POS = 2'd1,
        STAT_NO_FREE = 2'd2,
        STAT_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_INS_FREE = 8'b0000_0010,
        S_WALK     = 8'b0000_0100,
        S_INS_LINK = 8'b0000_1000,
        S_DEL_RD   = 8'b0001_0000,
        S_DEL_FREE = 8'b0010_0000,
        S_TR_EMIT  = 8'b0100_0000,
        S_RESULT   = 8'b1000_0000
    } state_t;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int POS_W       = 6;
    localparam int VAL_W       = 8;
    localparam int LEN_W       = 6;

endpackage

FILE: hdl/slle_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module slle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/static_linked_list_engine.sv
// Static linked list engine: array-backed list with a free chain, held in link and element RAMs.
// Depends on slle_pkg, slle_ram and static_linked_list_engine_assert.svh.
//
// One item is taken at a time. The link RAM has one read port with registered read data, and
// the walk to a list position follows one link per cycle. An insert at position p takes a slot
// off the free chain, walks to the element before p and links the new element in; a delete
// walks there, unlinks the element and returns its slot to the free chain. An error result or a
// clear goes straight to the result state. A traverse reads from the list head, then emits one
// element per cycle while the output is taken. The next item can be taken in the same cycle as
// the last result is raised. The longest walk is that of an insert or delete at position
// ARRAY_SIZE - 2. The free-chain head and list head live in registers; the reset and clear state
// of the link RAM comes from per-entry valid flops, so no clearing pass is needed.
`include "static_linked_list_engine_assert.svh"

module static_linked_list_engine
    import slle_pkg::*;
#(
    parameter int ARRAY_SIZE    = 64,
    parameter int ELEMENT_WIDTH = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // operation[1:0], position[7:2], value[15:8]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // status[1:0], element[9:2], list_length[15:10],
                                              // list_full[16], zero[23:17]
    output logic                   m_tlast
);

    localparam int LW   = $clog2(ARRAY_SIZE);
    localparam int CW   = $clog2(ARRAY_SIZE - 1);
    localparam int NW   = (CW > POS_W) ? CW : POS_W;
    localparam int CMPW = NW + 1;
    localparam logic [LW-1:0] HEAD = LW'(ARRAY_SIZE - 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(ARRAY_SIZE - 2);

    // Control state
    state_t                   state_reg, state_next;
    logic [LW-1:0]            free_head_reg, free_head_next;
    logic [LW-1:0]            list_head_reg, list_head_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [ARRAY_SIZE-1:0]    lvalid_reg, lvalid_next;
    logic                     m_tvalid_reg, m_tvalid_next;

    // Working registers
    logic [LW-1:0]            k_reg, k_next;
    logic [LW-1:0]            f_reg, f_next;
    logic [LW-1:0]            j_reg, j_next;
    logic [NW-1:0]            walk_reg, walk_next;
    logic                     ins_reg, ins_next;
    logic [ELEMENT_WIDTH-1:0] val_reg, val_next;
    status_t                  res_status_reg, res_status_next;
    logic [LW-1:0]            rd_addr_reg, rd_addr_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                     m_tlast_reg, m_tlast_next;

    // RAM ports
    logic                     lw_en;
    logic [LW-1:0]            lw_addr;
    logic [LW-1:0]            lw_data;
    logic                     ew_en;
    logic                     lr_en;
    logic [LW-1:0]            lr_addr;
    logic [LW-1:0]            ram_link;
    logic [ELEMENT_WIDTH-1:0] ram_elem;

    // Decoded input and derived values
    op_t                      in_op;
    logic [POS_W-1:0]         in_pos;
    logic [63:0]              in_val64;
    logic [CMPW-1:0]          pos_x;
    logic [CMPW-1:0]          cnt_x;
    logic [LW:0]              addr_p1;
    logic [LW-1:0]            rst_link;
    logic [LW-1:0]            rd_link;
    logic [LW-1:0]            k_link;
    logic [63:0]              elem64;
    logic                     out_free;
    logic                     list_full;

    slle_ram #(
        .WIDTH (LW),
        .DEPTH (ARRAY_SIZE)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (lw_en),
        .waddr (lw_addr),
        .wdata (lw_data),
        .re    (lr_en),
        .raddr (lr_addr),
        .rdata (ram_link)
    );

    slle_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (ARRAY_SIZE)
    ) u_elem_ram (
        .aclk  (aclk),
        .we    (ew_en),
        .waddr (f_reg),
        .wdata (val_reg),
        .re    (lr_en),
        .raddr (lr_addr),
        .rdata (ram_elem)
    );

    assign in_op    = op_t'(s_tdata[1:0]);
    assign in_pos   = s_tdata[7:2];
    assign in_val64 = 64'(s_tdata[15:8]);
    assign pos_x    = CMPW'(in_pos);
    assign cnt_x    = CMPW'(count_reg);
    assign elem64   = 64'(ram_elem);
    assign out_free = !m_tvalid_reg || m_tready;
    assign list_full = (free_head_reg == '0);

    // An entry never written since reset or clear reads as its free-chain default.
    assign addr_p1  = {1'b0, rd_addr_reg} + (LW+1)'(1);
    assign rst_link = (addr_p1 < (LW+1)'(ARRAY_SIZE - 1)) ? addr_p1[LW-1:0] : '0;
    assign rd_link  = rd_valid_reg ? ram_link : rst_link;
    assign k_link   = (k_reg == HEAD) ? list_head_reg : rd_link;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        state_next      = state_reg;
        free_head_next  = free_head_reg;
        list_head_next  = list_head_reg;
        count_next      = count_reg;
        lvalid_next     = lvalid_reg;
        m_tvalid_next   = m_tvalid_reg;
        k_next          = k_reg;
        f_next          = f_reg;
        j_next          = j_reg;
        walk_next       = walk_reg;
        ins_next        = ins_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;
        lw_en           = 1'b0;
        lw_addr         = '0;
        lw_data         = '0;
        ew_en           = 1'b0;
        lr_en           = 1'b0;
        lr_addr         = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    walk_next = NW'(in_pos) - NW'(1);
                    k_next    = HEAD;
                    val_next  = in_val64[ELEMENT_WIDTH-1:0];
                    unique case (in_op)
                        OP_INSERT: begin
                            ins_next = 1'b1;
                            if (in_pos == '0 || pos_x > cnt_x + CMPW'(1)) begin
                                res_status_next = STAT_BAD_POS;
                                state_next      = S_RESULT;
                            end else if (list_full) begin
                                res_status_next = STAT_NO_FREE;
                                state_next      = S_RESULT;
                            end else begin
                                lr_en      = 1'b1;
                                lr_addr    = free_head_reg;
                                f_next     = free_head_reg;
                                state_next = S_INS_FREE;
                            end
                        end
                        OP_DELETE: begin
                            ins_next = 1'b0;
                            if (count_reg == '0) begin
                                res_status_next = STAT_EMPTY;
                                state_next      = S_RESULT;
                            end else if (in_pos == '0 || pos_x > cnt_x) begin
                                res_status_next = STAT_BAD_POS;
                                state_next      = S_RESULT;
                            end else begin
                                state_next = S_WALK;
                            end
                        end
                        OP_TRAVERSE: begin
                            if (count_reg == '0) begin
                                res_status_next = STAT_EMPTY;
                                state_next      = S_RESULT;
                            end else begin
                                lr_en      = 1'b1;
                                lr_addr    = list_head_reg;
                                walk_next  = NW'(count_reg);
                                state_next = S_TR_EMIT;
                            end
                        end
                        OP_CLEAR: begin
                            lvalid_next     = '0;
                            free_head_next  = LW'(1);
                            list_head_next  = '0;
                            count_next      = '0;
                            res_status_next = STAT_OK;
                            state_next      = S_RESULT;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS_FREE: begin
                // Pop the taken slot off the free chain.
                free_head_next = rd_link;
                state_next     = S_WALK;
            end

            S_WALK: begin
                if (walk_reg != '0) begin
                    k_next    = k_link;
                    walk_next = walk_reg - NW'(1);
                    lr_en     = 1'b1;
                    lr_addr   = k_link;
                end else if (ins_reg) begin
                    lw_en      = 1'b1;
                    lw_addr    = f_reg;
                    lw_data    = k_link;
                    ew_en      = 1'b1;
                    state_next = S_INS_LINK;
                end else begin
                    j_next     = k_link;
                    lr_en      = 1'b1;
                    lr_addr    = k_link;
                    state_next = S_DEL_RD;
                end
            end

            S_INS_LINK: begin
                if (k_reg == HEAD) begin
                    list_head_next = f_reg;
                end else begin
                    lw_en   = 1'b1;
                    lw_addr = k_reg;
                    lw_data = f_reg;
                end
                count_next      = count_reg + CW'(1);
                res_status_next = STAT_OK;
                state_next      = S_RESULT;
            end

            S_DEL_RD: begin
                // Unlink the element: its predecessor takes its successor.
                if (k_reg == HEAD) begin
                    list_head_next = rd_link;
                end else begin
                    lw_en   = 1'b1;
                    lw_addr = k_reg;
                    lw_data = rd_link;
                end
                state_next = S_DEL_FREE;
            end

            S_DEL_FREE: begin
                lw_en           = 1'b1;
                lw_addr         = j_reg;
                lw_data         = free_head_reg;
                free_head_next  = j_reg;
                count_next      = count_reg - CW'(1);
                res_status_next = STAT_OK;
                state_next      = S_RESULT;
            end

            S_TR_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = (walk_reg == NW'(1));
                    m_tdata_next  = OUT_TDATA_W'({list_full, cnt_x[LEN_W-1:0],
                                                  elem64[VAL_W-1:0], STAT_OK});
                    walk_next     = walk_reg - NW'(1);
                    if (walk_reg == NW'(1)) begin
                        state_next = S_IDLE;
                    end else begin
                        lr_en   = 1'b1;
                        lr_addr = rd_link;
                    end
                end
            end

            S_RESULT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b1;
                    m_tdata_next  = OUT_TDATA_W'({list_full, cnt_x[LEN_W-1:0],
                                                  {VAL_W{1'b0}}, res_status_reg});
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (lw_en) begin
            lvalid_next[lw_addr] = 1'b1;
        end
    end

    assign rd_addr_next  = lr_en ? lr_addr : rd_addr_reg;
    assign rd_valid_next = lr_en ? lvalid_reg[lr_addr] : rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            free_head_reg <= LW'(1);
            list_head_reg <= '0;
            count_reg     <= '0;
            lvalid_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            list_head_reg <= list_head_next;
            count_reg     <= count_next;
            lvalid_reg    <= lvalid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg          <= k_next;
        f_reg          <= f_next;
        j_reg          <= j_next;
        walk_reg       <= walk_next;
        ins_reg        <= ins_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        rd_addr_reg    <= rd_addr_next;
        rd_valid_reg   <= rd_valid_next;
        m_tdata_reg    <= m_tdata_next;
        m_tlast_reg    <= m_tlast_next;
    end

    `SLLE_ASSERT(a_count_bound, (count_reg <= MAX_COUNT), "element count beyond capacity")
    `SLLE_ASSERT(a_head_not_free, (free_head_reg != HEAD), "head slot handed to free chain")
    `SLLE_ASSERT(a_full_matches_count,
        (state_reg == S_IDLE) |-> ((free_head_reg == '0) == (count_reg == MAX_COUNT)),
        "free chain and count disagree")
    `SLLE_ASSERT(a_empty_matches_head,
        (state_reg == S_IDLE) |-> ((list_head_reg == '0) == (count_reg == '0)),
        "list head and count disagree")
    `SLLE_ASSERT(a_trav_addr,
        (state_reg == S_TR_EMIT) |-> (rd_addr_reg != '0 && rd_addr_reg != HEAD),
        "traverse read a non-data slot")
    `SLLE_ASSERT_NEXT(a_clear_empties, s_tvalid && s_tready && in_op == OP_CLEAR,
        count_reg == '0 && list_head_reg == '0, "clear left elements")

endmodule
